// File: rtl/sbcf_pkg.sv
// ----------------------------------------------------------------------------
// sbcf_pkg
// Shared types and constants for the sprite blitter with clip and flip.
// ----------------------------------------------------------------------------
package sbcf_pkg;

	localparam int FB_WIDTH_DEF         = 320;
	localparam int FB_HEIGHT_DEF        = 240;
	localparam int MAX_SPRITE_WIDTH_DEF = 64;

	localparam int COORD_W       = 16;
	localparam int CHAN_W        = 8;
	localparam int WIDTH_FIELD_W = 7;
	localparam int ROW_W         = 16;
	localparam int RGB_W         = 3 * CHAN_W;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 16;

	typedef enum logic [1:0] {
		OP_SPRITE = 2'd0,
		OP_CLEAR  = 2'd1,
		OP_READ   = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_VIEW_X = 1'b0,
		CFG_VIEW_Y = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_ADDR,
		ST_MEM,
		ST_CLEAR,
		ST_RES
	} state_t;

	typedef struct packed {
		logic [1:0]               operation;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic                     is_static;
		logic                     flip;
		logic [WIDTH_FIELD_W-1:0] spr_width;
		logic                     first_pixel;
		logic [CHAN_W-1:0]        red;
		logic [CHAN_W-1:0]        green;
		logic [CHAN_W-1:0]        blue;
		logic [CHAN_W-1:0]        alpha;
	} in_word_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_red;
		logic [CHAN_W-1:0] out_green;
		logic [CHAN_W-1:0] out_blue;
		logic              drawn;
		logic              in_bounds;
	} out_word_t;

	typedef struct packed {
		logic load;
		logic calc;
		logic addr;
		logic mem;
		logic clr_step;
		logic out_load;
	} cmd_t;

endpackage

// File: rtl/sbcf_if.sv
// ----------------------------------------------------------------------------
// sbcf_if
// Valid/ready channels for the request and response words.
// ----------------------------------------------------------------------------
interface sbcf_req_if;
	logic                                        valid;
	logic                                        ready;
	logic [1:0]                                  operation;
	logic signed [sbcf_pkg::COORD_W-1:0]         pos_x;
	logic signed [sbcf_pkg::COORD_W-1:0]         pos_y;
	logic                                        is_static;
	logic                                        flip;
	logic [sbcf_pkg::WIDTH_FIELD_W-1:0]          spr_width;
	logic                                        first_pixel;
	logic [sbcf_pkg::CHAN_W-1:0]                 red;
	logic [sbcf_pkg::CHAN_W-1:0]                 green;
	logic [sbcf_pkg::CHAN_W-1:0]                 blue;
	logic [sbcf_pkg::CHAN_W-1:0]                 alpha;

	modport source (
		output valid, operation, pos_x, pos_y, is_static, flip, spr_width,
			first_pixel, red, green, blue, alpha,
		input  ready
	);
	modport sink (
		input  valid, operation, pos_x, pos_y, is_static, flip, spr_width,
			first_pixel, red, green, blue, alpha,
		output ready
	);
endinterface

interface sbcf_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [sbcf_pkg::CHAN_W-1:0] out_red;
	logic [sbcf_pkg::CHAN_W-1:0] out_green;
	logic [sbcf_pkg::CHAN_W-1:0] out_blue;
	logic                        drawn;
	logic                        in_bounds;

	modport source (
		output valid, out_red, out_green, out_blue, drawn, in_bounds,
		input  ready
	);
	modport sink (
		input  valid, out_red, out_green, out_blue, drawn, in_bounds,
		output ready
	);
endinterface

// File: rtl/sprite_blitter_clip_flip_core.sv
// ----------------------------------------------------------------------------
// sprite_blitter_clip_flip_core
// Framebuffer blitter: sprite pixel write with scroll, flip and clipping,
// framebuffer clear and pixel read, one response word per request word.
// ----------------------------------------------------------------------------
// One request word is worked on at a time. A sprite pixel or a read steps
// through accept, coordinate and clip, address multiply, framebuffer access
// and result load before the next word is accepted. A clear sweeps all
// FB_WIDTH*FB_HEIGHT framebuffer entries: the single
// framebuffer port writes one entry per cycle. The result register is
// separate, so a new word is accepted while the previous response waits.
// Reading a pixel never written since reset returns an undefined colour.
module sprite_blitter_clip_flip_core #(
	parameter int FB_WIDTH         = sbcf_pkg::FB_WIDTH_DEF,
	parameter int FB_HEIGHT        = sbcf_pkg::FB_HEIGHT_DEF,
	parameter int MAX_SPRITE_WIDTH = sbcf_pkg::MAX_SPRITE_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	sbcf_req_if.sink                           req,
	sbcf_rsp_if.source                         rsp,
	input  logic                               cfg_we,
	input  logic [sbcf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sbcf_pkg::CFG_DATA_W-1:0]    cfg_data
);

	sbcf_pkg::cmd_t      cmd;
	sbcf_pkg::in_word_t  in_word;
	sbcf_pkg::out_word_t out_word;
	logic                clr_last;
	logic                in_ready;
	logic                out_valid;

	assign in_word.operation    = req.operation;
	assign in_word.pos_x        = req.pos_x;
	assign in_word.pos_y        = req.pos_y;
	assign in_word.is_static    = req.is_static;
	assign in_word.flip         = req.flip;
	assign in_word.spr_width    = req.spr_width;
	assign in_word.first_pixel  = req.first_pixel;
	assign in_word.red          = req.red;
	assign in_word.green        = req.green;
	assign in_word.blue         = req.blue;
	assign in_word.alpha        = req.alpha;

	sbcf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_op     (req.operation),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (rsp.ready),
		.clr_last  (clr_last),
		.cmd       (cmd)
	);

	sbcf_datapath #(
		.FB_WIDTH         (FB_WIDTH),
		.FB_HEIGHT        (FB_HEIGHT),
		.MAX_SPRITE_WIDTH (MAX_SPRITE_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_word   (in_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_word  (out_word),
		.clr_last  (clr_last)
	);

	assign req.ready     = in_ready;
	assign rsp.valid     = out_valid;
	assign rsp.out_red   = out_word.out_red;
	assign rsp.out_green = out_word.out_green;
	assign rsp.out_blue  = out_word.out_blue;
	assign rsp.drawn     = out_word.drawn;
	assign rsp.in_bounds = out_word.in_bounds;

	// one word in flight
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while a word is in flight");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> rsp.valid)
		else $error("result load did not raise response valid");

	a_drawn_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.drawn |-> rsp.in_bounds)
		else $error("drawn pixel reported out of bounds");

	a_colour_only_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.in_bounds |->
			(rsp.out_red == '0) && (rsp.out_green == '0) && (rsp.out_blue == '0))
		else $error("colour returned without an in-bounds read");

endmodule

// File: rtl/sbcf_ctrl.sv
// ----------------------------------------------------------------------------
// sbcf_ctrl
// Sequencer: steps one word through calc, address, memory and result states,
// or through the clear sweep, and owns the result valid flag.
// ----------------------------------------------------------------------------
module sbcf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [1:0]           in_op,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  logic                 clr_last,
	output sbcf_pkg::cmd_t       cmd
);

	sbcf_pkg::state_t state_q;
	sbcf_pkg::state_t state_d;
	logic             out_valid_q;
	logic             slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sbcf_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			sbcf_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = (in_op == sbcf_pkg::OP_CLEAR) ? sbcf_pkg::ST_CLEAR
						: sbcf_pkg::ST_CALC;
				end
			end
			sbcf_pkg::ST_CALC:  state_d = sbcf_pkg::ST_ADDR;
			sbcf_pkg::ST_ADDR:  state_d = sbcf_pkg::ST_MEM;
			sbcf_pkg::ST_MEM:   state_d = sbcf_pkg::ST_RES;
			sbcf_pkg::ST_CLEAR: begin
				if (clr_last) begin
					state_d = sbcf_pkg::ST_RES;
				end
			end
			sbcf_pkg::ST_RES: begin
				if (slot_free) begin
					state_d = sbcf_pkg::ST_IDLE;
				end
			end
			default: state_d = sbcf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cmd          = '0;
		case (state_q)
			sbcf_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			sbcf_pkg::ST_CALC:  cmd.calc = 1'b1;
			sbcf_pkg::ST_ADDR:  cmd.addr = 1'b1;
			sbcf_pkg::ST_MEM:   cmd.mem = 1'b1;
			sbcf_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
			sbcf_pkg::ST_RES:   cmd.out_load = slot_free;
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// File: rtl/sbcf_datapath.sv
// ----------------------------------------------------------------------------
// sbcf_datapath
// View offset registers, sprite column/row counters, coordinate and clip
// logic, address multiply, framebuffer memory and result register.
// ----------------------------------------------------------------------------
module sbcf_datapath #(
	parameter int FB_WIDTH         = sbcf_pkg::FB_WIDTH_DEF,
	parameter int FB_HEIGHT        = sbcf_pkg::FB_HEIGHT_DEF,
	parameter int MAX_SPRITE_WIDTH = sbcf_pkg::MAX_SPRITE_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sbcf_pkg::cmd_t                     cmd,
	input  sbcf_pkg::in_word_t                 in_word,
	input  logic                               cfg_we,
	input  logic [sbcf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sbcf_pkg::CFG_DATA_W-1:0]    cfg_data,
	output sbcf_pkg::out_word_t                out_word,
	output logic                               clr_last
);

	localparam int DEPTH = FB_WIDTH * FB_HEIGHT;
	localparam int X_W   = (FB_WIDTH > 1) ? $clog2(FB_WIDTH) : 1;
	localparam int Y_W   = (FB_HEIGHT > 1) ? $clog2(FB_HEIGHT) : 1;
	localparam int A_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int COL_W = (MAX_SPRITE_WIDTH > 1) ? $clog2(MAX_SPRITE_WIDTH) : 1;
	localparam int W_W   = $clog2(MAX_SPRITE_WIDTH + 1);
	localparam int CW    = (W_W > sbcf_pkg::WIDTH_FIELD_W) ? W_W : sbcf_pkg::WIDTH_FIELD_W;
	localparam int OX_W  = sbcf_pkg::COORD_W + 1;
	localparam int CX_W  = ((OX_W > CW) ? OX_W : CW) + 2;
	localparam int CY_W  = ((OX_W > sbcf_pkg::ROW_W) ? OX_W : sbcf_pkg::ROW_W) + 2;
	localparam int RW    = sbcf_pkg::ROW_W;
	localparam int RGBW  = sbcf_pkg::RGB_W;
	localparam int CH    = sbcf_pkg::CHAN_W;

	localparam logic [CW-1:0]          MAXW_C = CW'(MAX_SPRITE_WIDTH);
	localparam logic signed [CX_W-1:0] FBW_S  = CX_W'(FB_WIDTH);
	localparam logic signed [CY_W-1:0] FBH_S  = CY_W'(FB_HEIGHT);
	localparam logic [A_W-1:0]         FBW_A  = A_W'(FB_WIDTH);
	localparam logic [A_W-1:0]         LAST_A = A_W'(DEPTH - 1);

	// config and counters
	logic signed [sbcf_pkg::COORD_W-1:0] off_x_q;
	logic signed [sbcf_pkg::COORD_W-1:0] off_y_q;
	logic [COL_W-1:0]                    col_q;
	logic [RW-1:0]                       row_q;

	// accept-cycle logic
	logic                   is_sprite;
	logic [CW-1:0]          w_in;
	logic [CW-1:0]          wc;
	logic [COL_W-1:0]       col0;
	logic [RW-1:0]          row0;
	logic [COL_W-1:0]       col_e;
	logic [RW-1:0]          row_e;
	logic [CW-1:0]          col_inc;
	logic signed [OX_W-1:0] ox;
	logic signed [OX_W-1:0] oy;
	logic [RGBW-1:0]        color;

	// stage 1
	logic [1:0]             op_s1;
	logic                   flip_s1;
	logic [CW-1:0]          wc_s1;
	logic [COL_W-1:0]       col_s1;
	logic [RW-1:0]          row_s1;
	logic signed [OX_W-1:0] ox_s1;
	logic signed [OX_W-1:0] oy_s1;
	logic [RGBW-1:0]        color_s1;

	// stage 2
	logic [CW-1:0]          offs;
	logic [RW-1:0]          row_add;
	logic signed [CX_W-1:0] cx;
	logic signed [CY_W-1:0] cy;
	logic                   inb;
	logic [X_W-1:0]         cx_s2;
	logic [Y_W-1:0]         cy_s2;
	logic                   inb_s2;

	// stage 3 and memory
	logic [A_W-1:0]         addr_s3;
	logic [A_W-1:0]         clr_q;
	logic [A_W-1:0]         mem_addr;
	logic                   mem_we;
	logic                   mem_re;
	logic [RGBW-1:0]        rd_q;
	logic [RGBW-1:0]        fb_mem [DEPTH];

	// result
	logic                   hit;
	sbcf_pkg::out_word_t    out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_x_q <= '0;
			off_y_q <= '0;
		end else if (cfg_we) begin
			case (sbcf_pkg::cfg_idx_t'(cfg_index))
				sbcf_pkg::CFG_VIEW_X: off_x_q <= cfg_data;
				sbcf_pkg::CFG_VIEW_Y: off_y_q <= cfg_data;
				default: begin
					off_x_q <= off_x_q;
				end
			endcase
		end
	end

	assign is_sprite = (in_word.operation == sbcf_pkg::OP_SPRITE);
	assign w_in      = CW'(in_word.spr_width);

	always_comb begin
		if (w_in == '0) begin
			wc = CW'(1);
		end else if (w_in > MAXW_C) begin
			wc = MAXW_C;
		end else begin
			wc = w_in;
		end
		col0 = in_word.first_pixel ? '0 : col_q;
		row0 = in_word.first_pixel ? '0 : row_q;
		if (CW'(col0) >= wc) begin
			col_e = '0;
			row_e = row0 + RW'(1);
		end else begin
			col_e = col0;
			row_e = row0;
		end
		col_inc = CW'(col_e) + CW'(1);
		if (in_word.is_static || !is_sprite) begin
			ox = OX_W'(in_word.pos_x);
			oy = OX_W'(in_word.pos_y);
		end else begin
			ox = OX_W'(in_word.pos_x) - OX_W'(off_x_q);
			oy = OX_W'(in_word.pos_y) - OX_W'(off_y_q);
		end
		if (is_sprite && (in_word.alpha == '0)) begin
			color = '0;
		end else begin
			color = {in_word.red, in_word.green, in_word.blue};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.load && is_sprite) begin
			if (col_inc >= wc) begin
				col_q <= '0;
				row_q <= row_e + RW'(1);
			end else begin
				col_q <= col_inc[COL_W-1:0];
				row_q <= row_e;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_s1    <= in_word.operation;
			flip_s1  <= in_word.flip;
			wc_s1    <= wc;
			col_s1   <= col_e;
			row_s1   <= row_e;
			ox_s1    <= ox;
			oy_s1    <= oy;
			color_s1 <= color;
		end
	end

	always_comb begin
		if (op_s1 == sbcf_pkg::OP_SPRITE) begin
			offs    = flip_s1 ? (wc_s1 - CW'(1) - CW'(col_s1)) : CW'(col_s1);
			row_add = row_s1;
		end else begin
			offs    = '0;
			row_add = '0;
		end
		cx  = CX_W'(ox_s1) + $signed(CX_W'(offs));
		cy  = CY_W'(oy_s1) + $signed(CY_W'(row_add));
		inb = !cx[CX_W-1] && (cx < FBW_S) && !cy[CY_W-1] && (cy < FBH_S)
			&& ((op_s1 == sbcf_pkg::OP_SPRITE) || (op_s1 == sbcf_pkg::OP_READ));
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			cx_s2  <= cx[X_W-1:0];
			cy_s2  <= cy[Y_W-1:0];
			inb_s2 <= inb;
		end
		if (cmd.addr) begin
			addr_s3 <= A_W'(cy_s2) * FBW_A + A_W'(cx_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.load) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + A_W'(1);
		end
	end

	assign clr_last = (clr_q == LAST_A);
	assign mem_addr = cmd.clr_step ? clr_q : addr_s3;
	assign mem_we   = cmd.clr_step || (cmd.mem && inb_s2 && (op_s1 == sbcf_pkg::OP_SPRITE));
	assign mem_re   = cmd.mem && inb_s2 && (op_s1 == sbcf_pkg::OP_READ);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			fb_mem[mem_addr] <= color_s1;
		end
		if (mem_re) begin
			rd_q <= fb_mem[mem_addr];
		end
	end

	assign hit = inb_s2
		&& ((op_s1 == sbcf_pkg::OP_SPRITE) || (op_s1 == sbcf_pkg::OP_READ));

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (hit && (op_s1 == sbcf_pkg::OP_READ)) begin
				out_q.out_red   <= rd_q[RGBW-1 -: CH];
				out_q.out_green <= rd_q[CH +: CH];
				out_q.out_blue  <= rd_q[CH-1:0];
			end else begin
				out_q.out_red   <= '0;
				out_q.out_green <= '0;
				out_q.out_blue  <= '0;
			end
			out_q.drawn     <= hit && (op_s1 == sbcf_pkg::OP_SPRITE);
			out_q.in_bounds <= hit;
		end
	end

	assign out_word = out_q;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sprite_blitter_clip_flip_core. It sends clears, sprite
// pixel streams, framebuffer reads and the unused opcode under random stalls on
// both channels and with scroll offset changes between phases. It also holds off
// responses for a long stretch so that the block backs up. Its own model of the
// framebuffer, the scroll registers and the sprite counters predicts each
// response word, which is checked field by field.
// ----------------------------------------------------------------------------
module testbench;
	import sbcf_pkg::*;

	localparam int         FB_W         = FB_WIDTH_DEF;
	localparam int         FB_H         = FB_HEIGHT_DEF;
	localparam int         SPR_MAX      = MAX_SPRITE_WIDTH_DEF;
	localparam logic [1:0] OP_UNUSED    = 2'd3;
	localparam int         CYCLE_LIMIT  = 2_000_000;
	localparam int         HOLD_CYCLES  = 300;
	localparam int         DRAIN_CYCLES = 10;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	sbcf_req_if req_ch ();
	sbcf_rsp_if rsp_ch ();

	sprite_blitter_clip_flip_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// model state
	logic [RGB_W-1:0]      fb_model [FB_W*FB_H];
	int                    col_cnt;
	logic [ROW_W-1:0]      row_cnt;
	logic [CFG_DATA_W-1:0] scroll_x;
	logic [CFG_DATA_W-1:0] scroll_y;
	out_word_t             pixel_results_due [$];

	int mismatches  = 0;
	int cycle_count = 0;
	int words_sent  = 0;
	int idle_pct    = 0;
	int clears_left = 2;
	bit hold_request = 1'b0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	function automatic bit on_screen(int x, int y);
		return x >= 0 && x < FB_W && y >= 0 && y < FB_H;
	endfunction

	// Predicts the response word and updates the model state.
	function automatic out_word_t blit_model(in_word_t w);
		out_word_t        res;
		int               wid;
		int               ox;
		int               oy;
		int               cx;
		int               cy;
		logic [RGB_W-1:0] rgb;
		res = '0;
		rgb = {w.red, w.green, w.blue};
		case (w.operation)
			OP_SPRITE: begin
				wid = int'(w.spr_width);
				if (wid < 1)
					wid = 1;
				if (wid > SPR_MAX)
					wid = SPR_MAX;
				if (w.first_pixel) begin
					col_cnt = 0;
					row_cnt = '0;
				end
				if (col_cnt >= wid) begin
					col_cnt = 0;
					row_cnt = row_cnt + 1'b1;
				end
				ox = int'($signed(w.pos_x));
				oy = int'($signed(w.pos_y));
				if (!w.is_static) begin
					ox -= int'($signed(scroll_x));
					oy -= int'($signed(scroll_y));
				end
				cx = w.flip ? ox + wid - 1 - col_cnt : ox + col_cnt;
				cy = oy + int'(row_cnt);
				if (on_screen(cx, cy)) begin
					fb_model[cy*FB_W + cx] = (w.alpha == 8'd0) ? '0 : rgb;
					res.drawn     = 1'b1;
					res.in_bounds = 1'b1;
				end
				col_cnt++;
				if (col_cnt >= wid) begin
					col_cnt = 0;
					row_cnt = row_cnt + 1'b1;
				end
			end
			OP_CLEAR: begin
				foreach (fb_model[i])
					fb_model[i] = rgb;
			end
			OP_READ: begin
				ox = int'($signed(w.pos_x));
				oy = int'($signed(w.pos_y));
				if (on_screen(ox, oy)) begin
					{res.out_red, res.out_green, res.out_blue} = fb_model[oy*FB_W + ox];
					res.in_bounds = 1'b1;
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic in_word_t sprite_word(int x, int y, bit stat, bit flp, int wid,
			bit first, logic [RGB_W-1:0] rgb, logic [CHAN_W-1:0] a);
		in_word_t w;
		w = '0;
		w.operation    = OP_SPRITE;
		w.pos_x        = x[COORD_W-1:0];
		w.pos_y        = y[COORD_W-1:0];
		w.is_static    = stat;
		w.flip         = flp;
		w.spr_width    = wid[WIDTH_FIELD_W-1:0];
		w.first_pixel  = first;
		{w.red, w.green, w.blue} = rgb;
		w.alpha        = a;
		return w;
	endfunction

	function automatic in_word_t read_word(int x, int y);
		in_word_t w;
		w = '0;
		w.operation = OP_READ;
		w.pos_x     = x[COORD_W-1:0];
		w.pos_y     = y[COORD_W-1:0];
		return w;
	endfunction

	function automatic in_word_t clear_word(logic [RGB_W-1:0] rgb);
		in_word_t w;
		w = '0;
		w.operation = OP_CLEAR;
		{w.red, w.green, w.blue} = rgb;
		return w;
	endfunction

	function automatic logic [CHAN_W-1:0] rand_alpha();
		return ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
	endfunction

	task automatic send_word(input in_word_t w);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.operation    <= w.operation;
		req_ch.pos_x        <= w.pos_x;
		req_ch.pos_y        <= w.pos_y;
		req_ch.is_static    <= w.is_static;
		req_ch.flip         <= w.flip;
		req_ch.spr_width    <= w.spr_width;
		req_ch.first_pixel  <= w.first_pixel;
		req_ch.red          <= w.red;
		req_ch.green        <= w.green;
		req_ch.blue         <= w.blue;
		req_ch.alpha        <= w.alpha;
		do @(posedge clk); while (!req_ch.ready);
		pixel_results_due.push_back(blit_model(w));
		words_sent++;
	endtask

	// Drop valid and wait until every response word is back.
	task automatic settle();
		req_ch.valid <= 1'b0;
		while (pixel_results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_scroll(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_VIEW_X)
			scroll_x = val;
		else
			scroll_y = val;
		@(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [CHAN_W-1:0] want,
			input logic [CHAN_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// response checker
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pixel_results_due.size() == 0) begin
				$error("response word with nothing expected");
				mismatches++;
			end else begin
				want = pixel_results_due.pop_front();
				check_field("out_red", want.out_red, rsp_ch.out_red);
				check_field("out_green", want.out_green, rsp_ch.out_green);
				check_field("out_blue", want.out_blue, rsp_ch.out_blue);
				check_field("drawn", 8'(want.drawn), 8'(rsp_ch.drawn));
				check_field("in_bounds", 8'(want.in_bounds), 8'(rsp_ch.in_bounds));
			end
		end
	end

	// response sink with random stalls and one long hold-off on request
	initial begin
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic test_clear_read();
		send_word(clear_word(24'hFF00AA));
		send_word(read_word(0, 0));
		send_word(read_word(FB_W-1, FB_H-1));
		send_word(read_word(-1, 0));
		send_word(read_word(FB_W, 0));
		send_word(read_word(0, FB_H));
		send_word(read_word(-32768, 32767));
		settle();
	endtask

	task automatic test_sprite_clip_flip();
		in_word_t odd;
		// flipped 3-wide sprite hanging off the bottom right corner
		for (int i = 0; i < 6; i++)
			send_word(sprite_word(FB_W-2, FB_H-2, 1'b1, 1'b1, 3, i == 0, 24'($urandom),
				(i == 2) ? 8'd0 : 8'($urandom_range(1, 255))));
		// zero width acts as one
		send_word(sprite_word(5, 5, 1'b1, 1'b0, 0, 1'b1, 24'($urandom), 8'hFF));
		send_word(sprite_word(5, 5, 1'b1, 1'b0, 0, 1'b0, 24'($urandom), 8'hFF));
		// oversize width clamps
		send_word(sprite_word(0, 10, 1'b1, 1'b1, 127, 1'b1, 24'($urandom), 8'h80));
		// width shrinks mid-sprite
		for (int i = 0; i < 4; i++)
			send_word(sprite_word(20, 20, 1'b1, 1'b0, (i == 3) ? 2 : 4, i == 0,
				24'($urandom), 8'h01));
		odd = clear_word(24'($urandom));
		odd.operation = OP_UNUSED;
		odd.pos_x     = 16'd3;
		send_word(odd);
		send_word(read_word(FB_W-1, FB_H-2));
		send_word(read_word(FB_W-2, FB_H-1));
		send_word(read_word(5, 6));
		send_word(read_word(63, 10));
		send_word(read_word(20, 21));
		settle();
	endtask

	task automatic test_scroll_extremes();
		write_scroll(CFG_VIEW_X, 16'h7FFF);
		write_scroll(CFG_VIEW_Y, 16'h8000);
		send_word(sprite_word(32767, -32768, 1'b0, 1'b0, 1, 1'b1, 24'($urandom), 8'hFF));
		send_word(sprite_word(1, 1, 1'b1, 1'b0, 1, 1'b1, 24'($urandom), 8'hFF));
		settle();
		write_scroll(CFG_VIEW_X, 16'h8000);
		write_scroll(CFG_VIEW_Y, 16'h7FFF);
		send_word(sprite_word(-32766, 32767, 1'b0, 1'b0, 1, 1'b1, 24'($urandom), 8'hFF));
		send_word(read_word(0, 0));
		send_word(read_word(2, 0));
		send_word(read_word(1, 1));
		settle();
	endtask

	task automatic test_output_hold();
		idle_pct     = 0;
		hold_request = 1'b1;
		repeat (12) send_word(read_word($urandom_range(0, FB_W-1), $urandom_range(0, FB_H-1)));
		settle();
	endtask

	task automatic random_sprite();
		int wid;
		int w_eff;
		int rows;
		int n;
		int sx;
		int sy;
		int px;
		int py;
		int chg;
		bit stat;
		bit flp;
		case ($urandom_range(0, 9))
			0:       wid = $urandom_range(SPR_MAX+1, 127);
			1:       wid = 0;
			2, 3:    wid = $urandom_range(17, SPR_MAX);
			default: wid = $urandom_range(1, 16);
		endcase
		w_eff = (wid < 1) ? 1 : (wid > SPR_MAX) ? SPR_MAX : wid;
		rows  = $urandom_range(1, 3);
		n     = (w_eff * rows > 40) ? 40 : w_eff * rows;
		stat  = 1'($urandom_range(0, 1));
		flp   = 1'($urandom_range(0, 1));
		sx    = int'($urandom_range(0, FB_W + 40)) - 20 - w_eff / 2;
		sy    = int'($urandom_range(0, FB_H + 10)) - 5;
		px    = stat ? sx : sx + int'($signed(scroll_x));
		py    = stat ? sy : sy + int'($signed(scroll_y));
		chg   = (n > 1 && $urandom_range(0, 7) == 0) ? $urandom_range(1, n-1) : n;
		for (int i = 0; i < n; i++)
			send_word(sprite_word(px, py, stat, flp,
				(i >= chg) ? $urandom_range(1, SPR_MAX) : wid,
				i == 0, 24'($urandom), rand_alpha()));
		repeat (2)
			send_word(read_word(sx + $urandom_range(0, w_eff-1), sy + $urandom_range(0, rows-1)));
	endtask

	task automatic random_noise();
		logic [95:0] raw;
		in_word_t    w;
		raw = {$urandom, $urandom, $urandom};
		w   = raw[$bits(in_word_t)-1:0];
		if (w.operation == OP_CLEAR) begin
			if (clears_left > 0)
				clears_left--;
			else
				w.operation = OP_READ;
		end
		send_word(w);
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_scroll();
		case ($urandom_range(0, 5))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			2:       return '0;
			default: return 16'(int'($urandom_range(0, 400)) - 200);
		endcase
	endfunction

	task automatic random_phase(input int n_words, input int pct);
		int start;
		settle();
		write_scroll(CFG_VIEW_X, pick_scroll());
		write_scroll(CFG_VIEW_Y, pick_scroll());
		idle_pct = pct;
		start    = words_sent;
		while (words_sent - start < n_words) begin
			case ($urandom_range(0, 19))
				0, 1, 2: random_noise();
				3, 4, 5, 6, 7:
					send_word(read_word($urandom_range(0, FB_W-1),
						$urandom_range(0, FB_H-1)));
				default: random_sprite();
			endcase
		end
	endtask

	initial begin
		arst_n              <= 1'b0;
		cfg_we              <= 1'b0;
		cfg_index           <= '0;
		cfg_data            <= '0;
		req_ch.valid        <= 1'b0;
		req_ch.operation    <= '0;
		req_ch.pos_x        <= '0;
		req_ch.pos_y        <= '0;
		req_ch.is_static    <= 1'b0;
		req_ch.flip         <= 1'b0;
		req_ch.spr_width    <= '0;
		req_ch.first_pixel  <= 1'b0;
		req_ch.red          <= '0;
		req_ch.green        <= '0;
		req_ch.blue         <= '0;
		req_ch.alpha        <= '0;
		col_cnt  = 0;
		row_cnt  = '0;
		scroll_x = '0;
		scroll_y = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_pct = 20;
		test_clear_read();
		test_sprite_clip_flip();
		test_scroll_extremes();
		test_output_hold();
		random_phase(100, 30);
		random_phase(100, 0);
		random_phase(100, 50);
		random_phase(100, 15);
		random_phase(100, 0);
		settle();
		if (mismatches == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
